// ----- hdl/swb_pkg.sv -----
// Shared types, widths and constants of the shadow wedge builder.
package swb_pkg;

  localparam int COORD_W     = 24;
  localparam int RAD_W       = 23;
  localparam int DIFF_W      = 25;
  localparam int PROD_W      = 49;
  localparam int SQ_W        = 49;
  localparam int DOT_W       = 50;
  localparam int R2_W        = 46;
  localparam int MUL_SPLIT   = 25;
  localparam int SQRT_IN_W   = 50;
  localparam int LEN_W       = SQRT_IN_W / 2;
  localparam int MAG_W       = 24;
  localparam int NUM_W       = 48;
  localparam int AREA_P_W    = 48;
  localparam int AREA_W      = 51;
  localparam int QUEUE_DEPTH = 4;
  localparam int IN_DATA_W   = 168;
  localparam int OUT_DATA_W  = 192;

  // flat-quad and endpoint-on-light tolerance in LSBs
  localparam int unsigned EPS_LSBS = 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  // first member sits in the highest bits, so light x lands at bit 0
  typedef struct packed {
    coord_t             by;
    coord_t             bx;
    coord_t             ay;
    coord_t             ax;
    logic [RAD_W-1:0]   rad;
    coord_t             ly;
    coord_t             lx;
  } item_t;

  typedef struct packed {
    item_t            item;
    logic [SQ_W-1:0]  la2;
    logic [SQ_W-1:0]  lb2;
    logic             keep;
  } job_t;

  typedef struct packed {
    item_t item;
    logic  keep;
  } side_t;

  typedef struct packed {
    coord_t c3y;
    coord_t c3x;
    coord_t c2y;
    coord_t c2x;
    coord_t c1y;
    coord_t c1x;
    coord_t c0y;
    coord_t c0x;
  } quad_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  localparam int JOB_W = $bits(job_t);

endpackage

// ----- hdl/swb_mul.sv -----
// Two-stage unsigned multiplier built from four partial products.
module swb_mul #(
  parameter int WA = swb_pkg::SQ_W,
  parameter int WB = swb_pkg::SQ_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int LO = swb_pkg::MUL_SPLIT;
  localparam int HA = WA - LO;
  localparam int HB = WB - LO;
  localparam int PW = WA + WB;

  logic [2*LO-1:0]  ll_r;
  logic [LO+HB-1:0] lh_r;
  logic [HA+LO-1:0] hl_r;
  logic [HA+HB-1:0] hh_r;
  logic [PW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[LO-1:0] * b[LO-1:0];
      lh_r <= a[LO-1:0] * b[WB-1:LO];
      hl_r <= a[WA-1:LO] * b[LO-1:0];
      hh_r <= a[WA-1:LO] * b[WB-1:LO];
      p_r  <= PW'(ll_r) + (PW'(lh_r) << LO) + (PW'(hl_r) << LO) + (PW'(hh_r) << (2 * LO));
    end
  end

  assign p = p_r;

endmodule

// ----- hdl/swb_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module swb_sqrt #(
  parameter int IN_W = swb_pkg::SQRT_IN_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   rad,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 1;
  localparam int TW    = OUT_W + 3;

  logic [IN_W-1:0]  rad_r  [OUT_W-1];
  logic [RW-1:0]    rem_r  [OUT_W-1];
  logic [OUT_W-1:0] root_r [OUT_W];

  for (genvar s = 0; s < OUT_W; s++) begin : g_stage
    logic [IN_W-1:0]  rad_i;
    logic [RW-1:0]    rem_i;
    logic [OUT_W-1:0] root_i;
    logic [TW-1:0]    t;
    logic [TW-1:0]    trial;
    logic [TW-1:0]    diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
    end

    // bring down the next two radicand bits and try 4*root + 1
    assign t     = {rem_i, rad_i[IN_W-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= {root_i[OUT_W-2:0], ge};
      end
    end

    if (s < OUT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[s] <= {rad_i[IN_W-3:0], 2'b00};
          rem_r[s] <= ge ? diff[RW-1:0] : t[RW-1:0];
        end
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

// ----- hdl/swb_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module swb_div #(
  parameter int NW = swb_pkg::NUM_W,
  parameter int DW = swb_pkg::LEN_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] num_r [NW-1];
  logic [DW-1:0] den_r [NW-1];
  logic [DW-1:0] rem_r [NW-1];
  logic [NW-1:0] quo_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] num_i;
    logic [DW-1:0] den_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] quo_i;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign num_i = num;
      assign den_i = den;
      assign rem_i = '0;
      assign quo_i = '0;
    end else begin : g_next
      assign num_i = num_r[s-1];
      assign den_i = den_r[s-1];
      assign rem_i = rem_r[s-1];
      assign quo_i = quo_r[s-1];
    end

    assign t    = {rem_i, num_i[NW-1]};
    assign diff = t - {1'b0, den_i};
    assign ge   = (t >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= {quo_i[NW-2:0], ge};
      end
    end

    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_r[s] <= {num_i[NW-2:0], 1'b0};
          den_r[s] <= den_i;
          rem_r[s] <= ge ? diff[DW-1:0] : t[DW-1:0];
        end
      end
    end
  end

  assign quo = quo_r[NW-1];

endmodule

// ----- hdl/swb_fifo.sv -----
// Small register queue between the classify front and the projection back.
module swb_fifo #(
  parameter int W     = swb_pkg::JOB_W,
  parameter int DEPTH = swb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [W-1:0]   din,
  input  logic           pop,
  output logic [W-1:0]   dout,
  output swb_pkg::qstat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign dout       = mem_r[rp_r];
  assign stat.full  = (cnt_r == (AW + 1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ----- hdl/swb_front.sv -----
// Front end: reach test against the light radius and endpoint-on-light cull.
module swb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  swb_pkg::item_t  in_item,
  input  logic            q_full,
  output logic            q_push,
  output swb_pkg::job_t   q_job
);

  localparam int DIFF_W = swb_pkg::DIFF_W;
  localparam int PROD_W = swb_pkg::PROD_W;
  localparam int SQ_W   = swb_pkg::SQ_W;
  localparam int DOT_W  = swb_pkg::DOT_W;
  localparam int R2_W   = swb_pkg::R2_W;
  localparam logic [SQ_W-1:0] EPS2 = SQ_W'(swb_pkg::EPS_LSBS * swb_pkg::EPS_LSBS);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  swb_pkg::item_t it1_r, it2_r, it3_r, it4_r, it5_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, wx_r, wy_r, ux_r, uy_r;
  logic signed [PROD_W-1:0] wdx_r, wdy_r, dxx_r, dyy_r, wxx_r, wyy_r, uxx_r, uyy_r;
  logic signed [PROD_W-1:0] cr1_r, cr2_r;
  logic [R2_W-1:0]          r2_2_r, r2_3_r;

  logic signed [DOT_W-1:0]  dot_r;
  logic [SQ_W-1:0]          dd_r, la2_3_r, lb2_3_r, cmag_r;
  logic signed [DOT_W-1:0]  xprod;

  logic [SQ_W-1:0]          la2_4_r, lb2_4_r, la2_5_r, lb2_5_r;
  logic                     mid4_r, ptk4_r, eps4_r, mid5_r, ptk5_r, eps5_r;

  logic [2*SQ_W-1:0]        c2;
  logic [R2_W+SQ_W-1:0]     rdd;
  logic                     dot_le0, dot_ge_dd, keep;

  assign en       = !(v5_r && q_full);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    xprod     = DOT_W'(cr1_r) - DOT_W'(cr2_r);
    dot_le0   = dot_r[DOT_W-1] || (dot_r == '0);
    dot_ge_dd = (dot_r >= $signed(DOT_W'(dd_r)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge direction, light relative to a, light relative to b
      it1_r <= in_item;
      dx_r  <= DIFF_W'(in_item.bx) - DIFF_W'(in_item.ax);
      dy_r  <= DIFF_W'(in_item.by) - DIFF_W'(in_item.ay);
      wx_r  <= DIFF_W'(in_item.lx) - DIFF_W'(in_item.ax);
      wy_r  <= DIFF_W'(in_item.ly) - DIFF_W'(in_item.ay);
      ux_r  <= DIFF_W'(in_item.lx) - DIFF_W'(in_item.bx);
      uy_r  <= DIFF_W'(in_item.ly) - DIFF_W'(in_item.by);

      it2_r  <= it1_r;
      wdx_r  <= wx_r * dx_r;
      wdy_r  <= wy_r * dy_r;
      dxx_r  <= dx_r * dx_r;
      dyy_r  <= dy_r * dy_r;
      wxx_r  <= wx_r * wx_r;
      wyy_r  <= wy_r * wy_r;
      uxx_r  <= ux_r * ux_r;
      uyy_r  <= uy_r * uy_r;
      cr1_r  <= wx_r * dy_r;
      cr2_r  <= wy_r * dx_r;
      r2_2_r <= it1_r.rad * it1_r.rad;

      it3_r   <= it2_r;
      dot_r   <= DOT_W'(wdx_r) + DOT_W'(wdy_r);
      dd_r    <= SQ_W'(dxx_r[PROD_W-2:0]) + SQ_W'(dyy_r[PROD_W-2:0]);
      la2_3_r <= SQ_W'(wxx_r[PROD_W-2:0]) + SQ_W'(wyy_r[PROD_W-2:0]);
      lb2_3_r <= SQ_W'(uxx_r[PROD_W-2:0]) + SQ_W'(uyy_r[PROD_W-2:0]);
      cmag_r  <= xprod[DOT_W-1] ? SQ_W'(-xprod) : SQ_W'(xprod);
      r2_3_r  <= r2_2_r;

      // beyond either end the nearest point is that endpoint
      it4_r   <= it3_r;
      la2_4_r <= la2_3_r;
      lb2_4_r <= lb2_3_r;
      mid4_r  <= !dot_le0 && !dot_ge_dd;
      ptk4_r  <= dot_le0 ? (la2_3_r <= SQ_W'(r2_3_r)) : (lb2_3_r <= SQ_W'(r2_3_r));
      eps4_r  <= (la2_3_r <= EPS2) || (lb2_3_r <= EPS2);

      it5_r   <= it4_r;
      la2_5_r <= la2_4_r;
      lb2_5_r <= lb2_4_r;
      mid5_r  <= mid4_r;
      ptk5_r  <= ptk4_r;
      eps5_r  <= eps4_r;
    end
  end

  swb_mul #(.WA(SQ_W), .WB(SQ_W)) u_mul_cross (
    .clk (clk),
    .en  (en),
    .a   (cmag_r),
    .b   (cmag_r),
    .p   (c2)
  );

  swb_mul #(.WA(R2_W), .WB(SQ_W)) u_mul_reach (
    .clk (clk),
    .en  (en),
    .a   (r2_3_r),
    .b   (dd_r),
    .p   (rdd)
  );

  // inside the span compare cross^2 against r^2 * |d|^2
  assign keep = (mid5_r ? !(c2 > (2 * SQ_W)'(rdd)) : ptk5_r) && !eps5_r;

  assign q_push     = v5_r && !q_full;
  assign q_job.item = it5_r;
  assign q_job.la2  = la2_5_r;
  assign q_job.lb2  = lb2_5_r;
  assign q_job.keep = keep;

endmodule

// ----- hdl/swb_back.sv -----
// Back end: project endpoints to the radius, shoelace area, winding fix.
module swb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  swb_pkg::qstat_t  q_stat,
  input  swb_pkg::job_t    q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_keep,
  output swb_pkg::quad_t   out_quad
);

  localparam int DIFF_W   = swb_pkg::DIFF_W;
  localparam int MAG_W    = swb_pkg::MAG_W;
  localparam int NUM_W    = swb_pkg::NUM_W;
  localparam int LEN_W    = swb_pkg::LEN_W;
  localparam int SQRT_W   = swb_pkg::SQRT_IN_W;
  localparam int AREA_P_W = swb_pkg::AREA_P_W;
  localparam int AREA_W   = swb_pkg::AREA_W;
  localparam int SQ_LAT   = SQRT_W / 2;
  localparam int DIV_LAT  = NUM_W;
  localparam logic signed [AREA_W-1:0] EPS_A = AREA_W'(swb_pkg::EPS_LSBS);

  logic en;

  logic            sv_r [SQ_LAT];
  swb_pkg::side_t  sd_r [SQ_LAT];
  logic [LEN_W-1:0] len_a, len_b;

  logic             mv_r;
  swb_pkg::side_t   ms_r;
  logic [NUM_W-2:0] pax_r, pay_r, pbx_r, pby_r;
  logic [LEN_W-1:0] lena_m_r, lenb_m_r;

  logic             nv_r;
  swb_pkg::side_t   ns_r;
  logic [NUM_W-1:0] nax_r, nay_r, nbx_r, nby_r;
  logic [LEN_W-1:0] lena_n_r, lenb_n_r;

  logic             dv_r [DIV_LAT];
  swb_pkg::side_t   ds_r [DIV_LAT];
  logic [NUM_W-1:0] qax, qay, qbx, qby;

  logic             pv_r;
  logic             pk_r;
  swb_pkg::quad_t   pq_r;

  logic                       av_r;
  logic                       ak_r;
  swb_pkg::quad_t             aq_r;
  logic signed [AREA_P_W-1:0] ap_r [8];

  logic                       vo_r;
  logic                       ko_r;
  swb_pkg::quad_t             qo_r;

  logic signed [DIFF_W-1:0]   dax, day, dbx, dby;
  logic signed [AREA_W-1:0]   area;
  logic                       flat, keep_f;
  swb_pkg::quad_t             quad_f;
  swb_pkg::item_t             mit, pit;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  // light plus or minus the offset, held to the coordinate range
  function automatic swb_pkg::coord_t project(input swb_pkg::coord_t l,
                                              input swb_pkg::coord_t p,
                                              input logic [NUM_W-1:0] q);
    logic signed [NUM_W+1:0] acc;
    acc = (p < l) ? (NUM_W + 2)'(l) - $signed({2'b00, q})
                  : (NUM_W + 2)'(l) + $signed({2'b00, q});
    if (acc > (NUM_W + 2)'(swb_pkg::COORD_MAX)) begin
      return swb_pkg::COORD_MAX;
    end else if (acc < (NUM_W + 2)'(swb_pkg::COORD_MIN)) begin
      return swb_pkg::COORD_MIN;
    end
    return acc[swb_pkg::COORD_W-1:0];
  endfunction

  assign en    = !(vo_r && !out_ready);
  assign q_pop = en && !q_stat.empty;

  swb_sqrt #(.IN_W(SQRT_W)) u_sqrt_a (
    .clk  (clk),
    .en   (en),
    .rad  (SQRT_W'(q_job.la2)),
    .root (len_a)
  );

  swb_sqrt #(.IN_W(SQRT_W)) u_sqrt_b (
    .clk  (clk),
    .en   (en),
    .rad  (SQRT_W'(q_job.lb2)),
    .root (len_b)
  );

  always_comb begin
    mit = sd_r[SQ_LAT-1].item;
    dax = DIFF_W'(mit.ax) - DIFF_W'(mit.lx);
    day = DIFF_W'(mit.ay) - DIFF_W'(mit.ly);
    dbx = DIFF_W'(mit.bx) - DIFF_W'(mit.lx);
    dby = DIFF_W'(mit.by) - DIFF_W'(mit.ly);
    pit = ds_r[DIV_LAT-1].item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_LAT; k++) begin
        sv_r[k] <= 1'b0;
      end
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_r[k] <= 1'b0;
      end
      mv_r <= 1'b0;
      nv_r <= 1'b0;
      pv_r <= 1'b0;
      av_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      sv_r[0] <= q_pop;
      for (int k = 1; k < SQ_LAT; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
      mv_r    <= sv_r[SQ_LAT-1];
      nv_r    <= mv_r;
      dv_r[0] <= nv_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
      pv_r <= dv_r[DIV_LAT-1];
      av_r <= pv_r;
      vo_r <= av_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= '{item: q_job.item, keep: q_job.keep};
      for (int k = 1; k < SQ_LAT; k++) begin
        sd_r[k] <= sd_r[k-1];
      end

      // |delta| * radius for each offset component
      ms_r     <= sd_r[SQ_LAT-1];
      pax_r    <= mag_of(dax) * mit.rad;
      pay_r    <= mag_of(day) * mit.rad;
      pbx_r    <= mag_of(dbx) * mit.rad;
      pby_r    <= mag_of(dby) * mit.rad;
      lena_m_r <= len_a;
      lenb_m_r <= len_b;

      // add half the length to round to nearest
      ns_r     <= ms_r;
      nax_r    <= NUM_W'(pax_r) + NUM_W'(lena_m_r >> 1);
      nay_r    <= NUM_W'(pay_r) + NUM_W'(lena_m_r >> 1);
      nbx_r    <= NUM_W'(pbx_r) + NUM_W'(lenb_m_r >> 1);
      nby_r    <= NUM_W'(pby_r) + NUM_W'(lenb_m_r >> 1);
      lena_n_r <= lena_m_r;
      lenb_n_r <= lenb_m_r;

      ds_r[0] <= ns_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        ds_r[k] <= ds_r[k-1];
      end

      pk_r     <= ds_r[DIV_LAT-1].keep;
      pq_r.c0x <= pit.ax;
      pq_r.c0y <= pit.ay;
      pq_r.c1x <= pit.bx;
      pq_r.c1y <= pit.by;
      pq_r.c2x <= project(pit.lx, pit.bx, qbx);
      pq_r.c2y <= project(pit.ly, pit.by, qby);
      pq_r.c3x <= project(pit.lx, pit.ax, qax);
      pq_r.c3y <= project(pit.ly, pit.ay, qay);

      ak_r     <= pk_r;
      aq_r     <= pq_r;
      ap_r[0]  <= pq_r.c0x * pq_r.c1y;
      ap_r[1]  <= pq_r.c0y * pq_r.c1x;
      ap_r[2]  <= pq_r.c1x * pq_r.c2y;
      ap_r[3]  <= pq_r.c1y * pq_r.c2x;
      ap_r[4]  <= pq_r.c2x * pq_r.c3y;
      ap_r[5]  <= pq_r.c2y * pq_r.c3x;
      ap_r[6]  <= pq_r.c3x * pq_r.c0y;
      ap_r[7]  <= pq_r.c3y * pq_r.c0x;

      ko_r <= keep_f;
      qo_r <= quad_f;
    end
  end

  swb_div #(.NW(NUM_W), .DW(LEN_W)) u_div_ax (
    .clk (clk), .en (en), .num (nax_r), .den (lena_n_r), .quo (qax)
  );

  swb_div #(.NW(NUM_W), .DW(LEN_W)) u_div_ay (
    .clk (clk), .en (en), .num (nay_r), .den (lena_n_r), .quo (qay)
  );

  swb_div #(.NW(NUM_W), .DW(LEN_W)) u_div_bx (
    .clk (clk), .en (en), .num (nbx_r), .den (lenb_n_r), .quo (qbx)
  );

  swb_div #(.NW(NUM_W), .DW(LEN_W)) u_div_by (
    .clk (clk), .en (en), .num (nby_r), .den (lenb_n_r), .quo (qby)
  );

  // doubled shoelace area, then drop flat quads and flip negative winding
  always_comb begin
    area = '0;
    for (int k = 0; k < 4; k++) begin
      area = area + AREA_W'(ap_r[2*k]) - AREA_W'(ap_r[2*k+1]);
    end
    flat   = (area <= EPS_A) && (area >= -EPS_A);
    keep_f = ak_r && !flat;
    quad_f = aq_r;
    if (!keep_f) begin
      quad_f = '0;
    end else if (area[AREA_W-1]) begin
      quad_f.c0x = aq_r.c3x;
      quad_f.c0y = aq_r.c3y;
      quad_f.c1x = aq_r.c2x;
      quad_f.c1y = aq_r.c2y;
      quad_f.c2x = aq_r.c1x;
      quad_f.c2y = aq_r.c1y;
      quad_f.c3x = aq_r.c0x;
      quad_f.c3y = aq_r.c0y;
    end
  end

  assign out_valid = vo_r;
  assign out_keep  = ko_r;
  assign out_quad  = qo_r;

endmodule

// ----- hdl/shadow_wedge_builder_unit.sv -----
// Top level of the shadow wedge builder: stream ports, front, queue and back.
//
// Takes one light/edge pair per clock and returns one result per pair, in
// order, at a sustained rate of one per cycle while out_tready stays high.
// A pair passes from its input transfer to its result through the reach-test
// front, the queue, the square-root pipeline, the stages that form the
// rounded numerators, the one-bit-per-stage divider pipeline and the stages
// for projection, shoelace area and winding. The back end stalls only while
// a finished result waits on out_tready; the queue lets the front keep taking
// pairs until it fills. A culled edge returns keep low and all corners zero.
module shadow_wedge_builder_unit #(
  parameter int QUEUE_DEPTH = swb_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // light_x, light_y, light_radius, edge_ax, edge_ay, edge_bx, edge_by, pad
  input  logic [swb_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, ..., corner3_x, corner3_y
  output logic [swb_pkg::OUT_DATA_W-1:0]  out_tdata,
  // keep
  output logic [0:0]                      out_tuser
);

  swb_pkg::item_t  in_item;
  swb_pkg::job_t   f_job;
  swb_pkg::job_t   b_job;
  swb_pkg::qstat_t q_stat;
  swb_pkg::quad_t  quad;
  logic [swb_pkg::JOB_W-1:0] q_dout;
  logic q_push;
  logic q_pop;
  logic keep;

  assign in_item = in_tdata[$bits(swb_pkg::item_t)-1:0];

  swb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_job    (f_job)
  );

  swb_fifo #(.W(swb_pkg::JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (f_job),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  assign b_job = q_dout;

  swb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_job     (b_job),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_keep  (keep),
    .out_quad  (quad)
  );

  assign out_tdata    = quad;
  assign out_tuser[0] = keep;

endmodule
